>>> hw/rtl/pem_pkg.sv
package pem_pkg;

	// register indexes of the configuration port
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam int CFG_BITS   = 13;
	localparam int COORD_BITS = 12;
	localparam int PIX_BITS   = 8;
	localparam int GRAD_BITS  = 11;	// signed, +/-765
	localparam int SQ_BITS    = 20;	// 765*765 fits
	localparam int SUM_BITS   = 21;

	localparam logic [CFG_BITS-1:0] MIN_DIM       = 13'd3;
	localparam logic [CFG_BITS-1:0] MAX_DIM       = 13'd4096;
	localparam logic [CFG_BITS-1:0] RESET_WIDTH   = 13'd640;
	localparam logic [CFG_BITS-1:0] RESET_HEIGHT  = 13'd480;
	localparam logic [PIX_BITS-1:0] STRENGTH_SAT  = 8'd255;

	localparam int QDEPTH    = 4;
	localparam int QPTR_BITS = 2;

	// one classified pixel, handed from the front end to the back end
	typedef struct packed {
		logic [COORD_BITS-1:0] row;      // input row
		logic [COORD_BITS-1:0] col;      // input column
		logic [COORD_BITS-1:0] res_row;  // row of the first result
		logic [COORD_BITS-1:0] res_col;  // column of the first result
		logic                  has_col_end;
		logic                  has_row_end;
		logic                  interior;
		logic [GRAD_BITS-1:0]  gx;
		logic [GRAD_BITS-1:0]  gy;
	} work_t;

	typedef enum logic {
		F_FETCH,
		F_READY
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SQUARE,
		B_SUM,
		B_ROOT,
		B_EMIT0,
		B_EMIT1,
		B_EMIT2
	} back_state_t;

endpackage

>>> hw/rtl/pem_ram.sv
module pem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/pem_front.sv
module pem_front import pem_pkg::*; #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [PIX_BITS-1:0]     pixel_value,
	input  logic                    q_full,
	output logic                    q_push,
	output work_t                   q_item
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WLIM = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
	localparam logic [CFG_BITS-1:0] WLIM_V = CFG_BITS'(WLIM);
	localparam logic [CFG_BITS-1:0] RST_W = (RESET_WIDTH > WLIM_V) ? WLIM_V : RESET_WIDTH;

	front_state_t state_q, state_d;

	logic [COORD_BITS-1:0] last_col_q, last_row_q;
	logic [COORD_BITS-1:0] row_q, col_q;
	logic [PIX_BITS-1:0]   win_q [6];	// [0..2] column c-2, [3..5] column c-1

	logic [CFG_BITS-1:0] w_clamp, h_clamp;
	logic                restart, accept;
	logic                ram_re;
	logic [AW-1:0]       ram_addr;
	logic [PIX_BITS-1:0] top_px, mid_px;
	logic [9:0]          lsum, rsum, tsum, bsum;
	logic signed [GRAD_BITS-1:0] gx, gy;
	logic                row_zero, col_zero, at_last_col, at_last_row;

	assign restart  = cfg_write && (cfg_index == REG_FRAME_WIDTH ||
		cfg_index == REG_FRAME_HEIGHT);
	assign accept   = in_valid && !in_stall;
	assign ram_addr = AW'(col_q);

	always_comb begin
		if (cfg_data < MIN_DIM) begin
			w_clamp = MIN_DIM;
		end else if (cfg_data > WLIM_V) begin
			w_clamp = WLIM_V;
		end else begin
			w_clamp = cfg_data;
		end
		if (cfg_data < MIN_DIM) begin
			h_clamp = MIN_DIM;
		end else if (cfg_data > MAX_DIM) begin
			h_clamp = MAX_DIM;
		end else begin
			h_clamp = cfg_data;
		end
	end

	// upper store holds row r-2, lower store row r-1
	pem_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (accept),
		.waddr (ram_addr),
		.wdata (mid_px),
		.re    (ram_re),
		.raddr (ram_addr),
		.rdata (top_px)
	);

	pem_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_lower (
		.clk   (clk),
		.we    (accept),
		.waddr (ram_addr),
		.wdata (pixel_value),
		.re    (ram_re),
		.raddr (ram_addr),
		.rdata (mid_px)
	);

	// Prewitt sums: left minus right column, top minus bottom row
	assign lsum = 10'(win_q[0]) + 10'(win_q[1]) + 10'(win_q[2]);
	assign rsum = 10'(top_px) + 10'(mid_px) + 10'(pixel_value);
	assign tsum = 10'(win_q[0]) + 10'(win_q[3]) + 10'(top_px);
	assign bsum = 10'(win_q[2]) + 10'(win_q[5]) + 10'(pixel_value);
	assign gx   = $signed({1'b0, lsum}) - $signed({1'b0, rsum});
	assign gy   = $signed({1'b0, tsum}) - $signed({1'b0, bsum});

	assign row_zero    = (row_q == '0);
	assign col_zero    = (col_q == '0);
	assign at_last_col = (col_q == last_col_q);
	assign at_last_row = (row_q == last_row_q);

	always_comb begin
		q_item.row         = row_q;
		q_item.col         = col_q;
		q_item.res_row     = row_zero ? '0 : row_q - 12'd1;
		q_item.res_col     = (row_zero || col_zero) ? col_q : col_q - 12'd1;
		q_item.has_col_end = !row_zero && at_last_col;
		q_item.has_row_end = !row_zero && at_last_row;
		q_item.interior    = (row_q[COORD_BITS-1:1] != '0) && (col_q[COORD_BITS-1:1] != '0);
		q_item.gx          = gx;
		q_item.gy          = gy;
	end

	always_comb begin
		state_d = state_q;
		if (restart) begin
			state_d = F_FETCH;
		end else begin
			case (state_q)
				F_FETCH: state_d = F_READY;
				F_READY: begin
					if (accept) begin
						state_d = F_FETCH;
					end
				end
				default: state_d = F_FETCH;
			endcase
		end
	end

	always_comb begin
		ram_re   = (state_q == F_FETCH);
		in_stall = !(state_q == F_READY && !q_full);
		q_push   = accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_FETCH;
			last_col_q <= COORD_BITS'(RST_W - 13'd1);
			last_row_q <= COORD_BITS'(RESET_HEIGHT - 13'd1);
			row_q      <= '0;
			col_q      <= '0;
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (restart) begin
				if (cfg_index == REG_FRAME_WIDTH) begin
					last_col_q <= COORD_BITS'(w_clamp - 13'd1);
				end else begin
					last_row_q <= COORD_BITS'(h_clamp - 13'd1);
				end
				row_q <= '0;
				col_q <= '0;
				for (int i = 0; i < 6; i++) begin
					win_q[i] <= '0;
				end
			end else if (accept) begin
				win_q[0] <= win_q[3];
				win_q[1] <= win_q[4];
				win_q[2] <= win_q[5];
				win_q[3] <= top_px;
				win_q[4] <= mid_px;
				win_q[5] <= pixel_value;
				if (at_last_col) begin
					col_q <= '0;
					row_q <= at_last_row ? '0 : row_q + 12'd1;
				end else begin
					col_q <= col_q + 12'd1;
				end
			end
		end
	end

endmodule

>>> hw/rtl/pem_queue.sv
module pem_queue import pem_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  work_t push_item,
	input  logic  pop,
	output work_t head,
	output logic  full,
	output logic  empty
);

	work_t               slot_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;

	assign head  = slot_q[rd_ptr_q];
	assign full  = (count_q == (QPTR_BITS+1)'(QDEPTH));
	assign empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/pem_back.sv
module pem_back import pem_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  work_t                 q_head,
	input  logic                  q_empty,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COORD_BITS-1:0] out_row,
	output logic [COORD_BITS-1:0] out_col,
	output logic [PIX_BITS-1:0]   edge_strength,
	output logic                  run_end
);

	back_state_t state_q, state_d;

	work_t               item_q;
	logic [SQ_BITS-1:0]  sqx_q, sqy_q;
	logic [SUM_BITS-1:0] sum_q;
	logic [PIX_BITS-1:0] mag_q;
	logic [2:0]          bit_idx_q;

	logic signed [2*GRAD_BITS-1:0] prod_x, prod_y;
	logic [PIX_BITS-1:0]   trial;
	logic [2*PIX_BITS-1:0] trial_sq;
	logic                  saturate;

	assign prod_x   = (2*GRAD_BITS)'($signed(item_q.gx)) * (2*GRAD_BITS)'($signed(item_q.gx));
	assign prod_y   = (2*GRAD_BITS)'($signed(item_q.gy)) * (2*GRAD_BITS)'($signed(item_q.gy));
	assign trial    = mag_q | (PIX_BITS'(1) << bit_idx_q);
	assign trial_sq = (2*PIX_BITS)'(trial) * (2*PIX_BITS)'(trial);
	assign saturate = (sum_q[SUM_BITS-1:2*PIX_BITS] != '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					state_d = q_head.interior ? B_SQUARE : B_EMIT0;
				end
			end
			B_SQUARE: state_d = B_SUM;
			B_SUM:    state_d = B_ROOT;
			B_ROOT: begin
				if (saturate || bit_idx_q == '0) begin
					state_d = B_EMIT0;
				end
			end
			B_EMIT0: begin
				if (!out_stall) begin
					if (item_q.has_col_end) begin
						state_d = B_EMIT1;
					end else if (item_q.has_row_end) begin
						state_d = B_EMIT2;
					end else begin
						state_d = B_IDLE;
					end
				end
			end
			B_EMIT1: begin
				if (!out_stall) begin
					state_d = item_q.has_row_end ? B_EMIT2 : B_IDLE;
				end
			end
			B_EMIT2: begin
				if (!out_stall) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop         = (state_q == B_IDLE) && !q_empty;
		out_valid     = 1'b0;
		out_row       = item_q.res_row;
		out_col       = item_q.res_col;
		edge_strength = '0;
		run_end       = 1'b0;
		case (state_q)
			B_EMIT0: begin
				out_valid     = 1'b1;
				edge_strength = mag_q;
				run_end       = !item_q.has_col_end && !item_q.has_row_end;
			end
			B_EMIT1: begin
				out_valid = 1'b1;
				out_col   = item_q.col;
				run_end   = !item_q.has_row_end;
			end
			B_EMIT2: begin
				out_valid = 1'b1;
				out_row   = item_q.row;
				out_col   = item_q.col;
				run_end   = 1'b1;
			end
			default: begin
				out_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath: squares, sum, then one root bit per cycle, msb first
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				item_q    <= q_head;
				mag_q     <= '0;
				bit_idx_q <= 3'd7;
			end
			B_SQUARE: begin
				sqx_q <= SQ_BITS'(prod_x);
				sqy_q <= SQ_BITS'(prod_y);
			end
			B_SUM: begin
				sum_q <= SUM_BITS'(sqx_q) + SUM_BITS'(sqy_q);
			end
			B_ROOT: begin
				if (saturate) begin
					mag_q <= STRENGTH_SAT;
				end else begin
					if (trial_sq <= sum_q[2*PIX_BITS-1:0]) begin
						mag_q <= trial;
					end
					bit_idx_q <= bit_idx_q - 3'd1;
				end
			end
			default: begin
				mag_q <= mag_q;
			end
		endcase
	end

endmodule

>>> hw/rtl/prewitt_edge_magnitude.sv
// Prewitt 3x3 edge magnitude on a raster stream of 8-bit grey pixels. Each
// accepted pixel request yields one to three results (row, column, strength),
// the last one flagged by run_end; output runs one row and one column behind
// the input, border pixels give strength 0 and interior ones
// floor(sqrt(gx^2+gy^2)) saturated at 255. The front end alternates a
// line-store read state with an accept state, so it takes a new pixel only
// after the line-store read for it is done. The back end fetches an item
// from the queue, then for an interior pixel squares, sums and runs the
// bit-serial square root msb first (cut short if saturated), then emits
// each result, holding it while out_stall is high. The root loop sets the
// sustained rate, the four-entry queue absorbs bursts. Writing frame_width
// or frame_height restarts the frame; the line stores need no clearing since
// values left from an earlier frame reach only border pixels (strength 0).
module prewitt_edge_magnitude import pem_pkg::*; #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration write channel
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	// pixel requests in
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [PIX_BITS-1:0]     pixel_value,
	// result requests out
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [COORD_BITS-1:0]   out_row,
	output logic [COORD_BITS-1:0]   out_col,
	output logic [PIX_BITS-1:0]     edge_strength,
	output logic                    run_end
);

	work_t push_item, head_item;
	logic  q_push, q_pop, q_full, q_empty;

	// registers are always writable
	assign cfg_ready = 1'b1;

	// front: counters, line stores, window, gradient sums
	pem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_value (pixel_value),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (push_item)
	);

	pem_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.head      (head_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	// back: magnitude and result sequencing
	pem_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_head        (head_item),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_row       (out_row),
		.out_col       (out_col),
		.edge_strength (edge_strength),
		.run_end       (run_end)
	);

endmodule
